FILE: rtl/qpe_pkg.sv
// qpe_pkg: types, character constants and helpers for the quoted-printable encoder
// no dependencies
`timescale 1ns / 1ps

package qpe_pkg;

	localparam int CFG_INDEX_W = 2;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_LINE_LIMIT    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PREFIX_LENGTH = 2'd1;

	localparam logic [7:0] LINE_LIMIT_RESET    = 8'd76;
	localparam logic [7:0] PREFIX_LENGTH_RESET = 8'd0;

	// character codes
	localparam logic [7:0] CHAR_EQUALS   = 8'h3D;
	localparam logic [7:0] CHAR_CR       = 8'h0D;
	localparam logic [7:0] CHAR_LF       = 8'h0A;
	localparam logic [7:0] CHAR_SPACE    = 8'h20;
	localparam logic [7:0] CHAR_TAB      = 8'h09;
	localparam logic [7:0] PRINT_LOW     = 8'd33;
	localparam logic [7:0] PRINT_HIGH    = 8'd126;

	// classified unit, handed from front to back
	typedef struct packed {
		logic [7:0] data_byte;
		logic       literal;
		logic       soft_break;
	} qpe_job_t;

	// upper-case hex digit for one nibble
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = 8'h30 + {4'h0, nib};
		end else begin
			c = 8'h37 + {4'h0, nib};
		end
		return c;
	endfunction

endpackage

FILE: rtl/qpe_if.sv
// qpe_if: handshake interfaces for input bytes, output characters and config writes
// depends on qpe_pkg
`timescale 1ns / 1ps

interface qpe_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       ascii_char;
	logic       end_of_text;
	modport source (output valid, output data_byte, output ascii_char, output end_of_text,
		input ready);
	modport sink (input valid, input data_byte, input ascii_char, input end_of_text,
		output ready);
endinterface

interface qpe_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       run_last;
	modport source (output valid, output out_char, output run_last, input ready);
	modport sink (input valid, input out_char, input run_last, output ready);
endinterface

interface qpe_cfg_if;
	import qpe_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [7:0]             data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/quoted_printable_encoder.sv
// quoted_printable_encoder: top level, front classifier, unit queue and serialiser
// depends on qpe_pkg, qpe_if, qpe_front, qpe_queue, qpe_back
`timescale 1ns / 1ps

// channel | dir | payload                              | request
// item    | in  | data_byte, ascii_char, end_of_text   | one text byte
// enc     | out | out_char, run_last                   | one encoded character
// cfg     | in  | index, data                          | one register write
//
// each byte yields 1 to 6 output characters: 1 for a literal, 3 for an escape, 3 more
// with a soft break; the serialiser emits one character a cycle while enc is not stalled and sets the rate
// the front takes a byte every cycle while the unit queue has room
// arst_n clears line state, queue pointers and output valid; config returns to 76 / 0
// a stalled enc channel fills the queue and then holds item ready low

module quoted_printable_encoder import qpe_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	qpe_item_if.sink      item,
	qpe_char_if.source    enc,
	qpe_cfg_if.sink       cfg
);

	qpe_job_t front_job;
	qpe_job_t head_job;
	logic     take;
	logic     q_full;
	logic     q_nonempty;
	logic     job_done;

	assign cfg.ready  = 1'b1;
	assign item.ready = !q_full;
	assign take       = item.valid && !q_full;

	// classification
	qpe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.take        (take),
		.data_byte   (item.data_byte),
		.ascii_char  (item.ascii_char),
		.end_of_text (item.end_of_text),
		.job         (front_job)
	);

	// decoupling queue
	qpe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (take),
		.push_job (front_job),
		.full     (q_full),
		.pop      (job_done),
		.nonempty (q_nonempty),
		.head     (head_job)
	);

	// serialiser
	qpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_nonempty),
		.job       (head_job),
		.job_done  (job_done),
		.out_valid (enc.valid),
		.out_ready (enc.ready),
		.out_char  (enc.out_char),
		.run_last  (enc.run_last)
	);

endmodule

FILE: rtl/qpe_front.sv
// qpe_front: config registers, byte classification and line length tracking
// depends on qpe_pkg
`timescale 1ns / 1ps

module qpe_front import qpe_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]             cfg_data,
	input  logic                   take,
	input  logic [7:0]             data_byte,
	input  logic                   ascii_char,
	input  logic                   end_of_text,
	output qpe_job_t               job
);

	logic [7:0] line_limit_q;
	logic [7:0] prefix_length_q;
	logic [7:0] line_length_q;
	logic       first_line_q;

	logic              literal;
	logic [1:0]        unit;
	logic signed [10:0] limit;
	logic signed [10:0] length_s;
	logic              soft_break;
	logic [7:0]        base_length;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_limit_q    <= LINE_LIMIT_RESET;
			prefix_length_q <= PREFIX_LENGTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LINE_LIMIT:    line_limit_q <= cfg_data;
				REG_PREFIX_LENGTH: prefix_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// literal or escaped
	always_comb begin
		literal = 1'b0;
		if (ascii_char) begin
			if (data_byte >= PRINT_LOW && data_byte <= PRINT_HIGH && data_byte != CHAR_EQUALS)
				literal = 1'b1;
			if (data_byte == CHAR_SPACE || data_byte == CHAR_TAB)
				literal = !end_of_text;
		end
		unit = literal ? 2'd1 : 2'd3;
	end

	// signed break test
	always_comb begin
		limit = $signed({3'b000, line_limit_q});
		if (first_line_q)
			limit = limit - $signed({3'b000, prefix_length_q});
		if (!end_of_text)
			limit = limit - 11'sd1;
		limit = limit - $signed({9'd0, unit});
		length_s = $signed({3'b000, line_length_q});
		soft_break = (line_length_q != 8'd0) && (length_s > limit);
		base_length = soft_break ? 8'd0 : line_length_q;
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= 8'd0;
			first_line_q  <= 1'b1;
		end else if (take) begin
			if (end_of_text) begin
				line_length_q <= 8'd0;
				first_line_q  <= 1'b1;
			end else begin
				line_length_q <= base_length + {6'd0, unit};
				if (soft_break)
					first_line_q <= 1'b0;
			end
		end
	end

	assign job.data_byte  = data_byte;
	assign job.literal    = literal;
	assign job.soft_break = soft_break;

endmodule

FILE: rtl/qpe_queue.sv
// qpe_queue: small register fifo of classified units between front and back
// depends on qpe_pkg
`timescale 1ns / 1ps

module qpe_queue import qpe_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  qpe_job_t push_job,
	output logic     full,
	input  logic     pop,
	output logic     nonempty,
	output qpe_job_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	qpe_job_t         entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == FULL_CNT);
	assign nonempty = (count_q != '0);
	assign head     = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_job;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: rtl/qpe_back.sv
// qpe_back: serialises one unit into characters, one a cycle while the output is not stalled, into an output register
// depends on qpe_pkg
`timescale 1ns / 1ps

module qpe_back import qpe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     job_valid,
	input  qpe_job_t job,
	output logic     job_done,
	output logic     out_valid,
	input  logic     out_ready,
	output logic [7:0] out_char,
	output logic     run_last
);

	logic [2:0] step_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       run_last_q;

	logic       load;
	logic [2:0] unit_step;
	logic [2:0] final_step;
	logic [7:0] next_char;
	logic       next_last;

	assign load = job_valid && (!out_valid_q || out_ready);

	// character for the current step
	always_comb begin
		unit_step  = job.soft_break ? step_q - 3'd3 : step_q;
		final_step = (job.soft_break ? 3'd3 : 3'd0) + (job.literal ? 3'd0 : 3'd2);
		next_last  = (step_q == final_step);
		if (job.soft_break && step_q < 3'd3) begin
			case (step_q)
				3'd0:    next_char = CHAR_EQUALS;
				3'd1:    next_char = CHAR_CR;
				default: next_char = CHAR_LF;
			endcase
		end else if (job.literal) begin
			next_char = job.data_byte;
		end else begin
			case (unit_step)
				3'd0:    next_char = CHAR_EQUALS;
				3'd1:    next_char = hex_char(job.data_byte[7:4]);
				default: next_char = hex_char(job.data_byte[3:0]);
			endcase
		end
	end

	assign job_done = load && next_last;

	// step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				step_q <= next_last ? 3'd0 : step_q + 3'd1;
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q <= next_char;
			run_last_q <= next_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign run_last  = run_last_q;

endmodule

FILE: tb/sv/tb_quoted_printable_encoder.sv
// tb_quoted_printable_encoder: self-checking bench for the quoted-printable encoder
// drives text bytes and register writes, predicts every encoded character and checks it
// depends on qpe_pkg, qpe_if and quoted_printable_encoder
`timescale 1ns / 1ps

module tb_quoted_printable_encoder;
	import qpe_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 16;

	// indexes past the register file, writes there must change nothing
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       ascii_char;
		logic       end_of_text;
	} text_byte_t;

	typedef struct packed {
		logic [CFG_INDEX_W-1:0] index;
		logic [7:0]             data;
	} reg_write_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       run_last;
	} enc_char_t;

	logic clk = 1'b0;
	logic arst_n;

	qpe_item_if item_ch ();
	qpe_char_if enc_ch ();
	qpe_cfg_if  cfg_ch ();

	quoted_printable_encoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.enc    (enc_ch),
		.cfg    (cfg_ch)
	);

	// predicted encoder state and register copy
	logic [7:0] enc_line_limit;
	logic [7:0] enc_prefix_length;
	logic [7:0] enc_line_length;
	logic       enc_first_line;

	text_byte_t pending_bytes_q[$];
	reg_write_t reg_writes_q[$];
	enc_char_t  encoded_chars_q[$];

	int fail_count  = 0;
	int cycle_count = 0;
	int send_gap;
	int sink_stall;
	bit send_burst;
	bit sink_burst;

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// gap length: mostly none or short, now and then long
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] nibble_digit(input logic [3:0] nib);
		if (nib > 4'd9) return 8'h41 + 8'(nib - 4'd10);
		return 8'h30 + 8'(nib);
	endfunction

	function automatic void push_char(input logic [7:0] c, input logic is_last);
		enc_char_t e;
		e.out_char = c;
		e.run_last = is_last;
		encoded_chars_q.push_back(e);
	endfunction

	// expected characters for one text byte, line state advanced
	function automatic void predict_encoding(input logic [7:0] b, input logic asc,
		input logic last);
		logic lit;
		int   unit_len;
		int   room;
		lit = 1'b0;
		if (asc) begin
			if (b >= PRINT_LOW && b <= PRINT_HIGH && b != CHAR_EQUALS) lit = 1'b1;
			if (b == CHAR_SPACE || b == CHAR_TAB) lit = !last;
		end
		unit_len = lit ? 1 : 3;
		room = int'(enc_line_limit);
		if (enc_first_line) room -= int'(enc_prefix_length);
		if (!last) room -= 1;
		// soft break, signed compare so a negative room breaks any nonempty line
		if (int'(enc_line_length) > room - unit_len && enc_line_length != 8'd0) begin
			push_char(CHAR_EQUALS, 1'b0);
			push_char(CHAR_CR, 1'b0);
			push_char(CHAR_LF, 1'b0);
			enc_line_length = 8'd0;
			enc_first_line  = 1'b0;
		end
		if (lit) begin
			push_char(b, 1'b1);
		end else begin
			push_char(CHAR_EQUALS, 1'b0);
			push_char(nibble_digit(b[7:4]), 1'b0);
			push_char(nibble_digit(b[3:0]), 1'b1);
		end
		enc_line_length = enc_line_length + 8'(unit_len);
		if (last) begin
			enc_line_length = 8'd0;
			enc_first_line  = 1'b1;
		end
	endfunction

	// driver for the item and cfg channels
	always @(posedge clk or negedge arst_n) begin
		text_byte_t next_byte;
		reg_write_t next_write;
		if (!arst_n) begin
			item_ch.valid       <= 1'b0;
			item_ch.data_byte   <= 8'd0;
			item_ch.ascii_char  <= 1'b0;
			item_ch.end_of_text <= 1'b0;
			cfg_ch.valid        <= 1'b0;
			cfg_ch.index        <= REG_LINE_LIMIT;
			cfg_ch.data         <= 8'd0;
			send_gap            <= 0;
			send_burst          <= 1'b0;
			enc_line_limit    = LINE_LIMIT_RESET;
			enc_prefix_length = PREFIX_LENGTH_RESET;
			enc_line_length   = 8'd0;
			enc_first_line    = 1'b1;
		end else begin
			// register write request taken
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_LINE_LIMIT:    enc_line_limit = cfg_ch.data;
					REG_PREFIX_LENGTH: enc_prefix_length = cfg_ch.data;
					default: ;
				endcase
			end
			if (!cfg_ch.valid || cfg_ch.ready) begin
				if (reg_writes_q.size() > 0) begin
					next_write = reg_writes_q.pop_front();
					cfg_ch.valid <= 1'b1;
					cfg_ch.index <= next_write.index;
					cfg_ch.data  <= next_write.data;
				end else begin
					cfg_ch.valid <= 1'b0;
				end
			end

			// text byte request taken
			if (item_ch.valid && item_ch.ready)
				predict_encoding(item_ch.data_byte, item_ch.ascii_char, item_ch.end_of_text);
			if (!item_ch.valid || item_ch.ready) begin
				if (send_gap > 0) begin
					item_ch.valid <= 1'b0;
					send_gap      <= send_gap - 1;
				end else if (pending_bytes_q.size() > 0) begin
					next_byte = pending_bytes_q.pop_front();
					item_ch.valid       <= 1'b1;
					item_ch.data_byte   <= next_byte.data_byte;
					item_ch.ascii_char  <= next_byte.ascii_char;
					item_ch.end_of_text <= next_byte.end_of_text;
					if ($urandom_range(0, 31) == 0) send_burst <= !send_burst;
					send_gap <= send_burst ? 0 : idle_length();
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor on the enc channel, with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		enc_char_t want;
		if (!arst_n) begin
			enc_ch.ready <= 1'b0;
			sink_stall   <= 0;
			sink_burst   <= 1'b0;
		end else begin
			if (enc_ch.valid && enc_ch.ready) begin
				if (encoded_chars_q.size() == 0) begin
					fail_count++;
					$error("enc request with nothing expected: out_char %02h run_last %0b",
						enc_ch.out_char, enc_ch.run_last);
				end else begin
					want = encoded_chars_q.pop_front();
					if (enc_ch.out_char !== want.out_char) begin
						fail_count++;
						$error("out_char: expected %02h, got %02h", want.out_char,
							enc_ch.out_char);
					end
					if (enc_ch.run_last !== want.run_last) begin
						fail_count++;
						$error("run_last: expected %0b, got %0b", want.run_last,
							enc_ch.run_last);
					end
				end
			end
			if ($urandom_range(0, 63) == 0) sink_burst <= !sink_burst;
			if (sink_stall > 0) begin
				enc_ch.ready <= 1'b0;
				sink_stall   <= sink_stall - 1;
			end else begin
				enc_ch.ready <= 1'b1;
				if (!sink_burst && $urandom_range(0, 3) == 0) sink_stall <= idle_length();
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_quoted_printable_encoder: errors");
			$finish;
		end
	end

	task automatic add_byte(input logic [7:0] b, input logic asc, input logic last);
		text_byte_t t;
		t.data_byte   = b;
		t.ascii_char  = asc;
		t.end_of_text = last;
		pending_bytes_q.push_back(t);
	endtask

	task automatic add_write(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] d);
		reg_write_t w;
		w.index = idx;
		w.data  = d;
		reg_writes_q.push_back(w);
	endtask

	// wait until every request is taken and every character has come out
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_bytes_q.size() > 0 || reg_writes_q.size() > 0 || item_ch.valid
			|| cfg_ch.valid || encoded_chars_q.size() > 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// one text of random bytes, mostly printable, closed by end_of_text
	task automatic add_random_text(input int n);
		int         k;
		int         r;
		logic [7:0] b;
		logic       asc;
		for (k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (k == n - 1 && $urandom_range(0, 3) == 0) r = 60;
			if (r < 55) begin
				b   = 8'($urandom_range(33, 126));
				asc = 1'b1;
			end else if (r < 67) begin
				b   = $urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB;
				asc = 1'b1;
			end else if (r < 82) begin
				b   = 8'($urandom_range(0, 255));
				asc = 1'b0;
			end else begin
				b   = 8'($urandom_range(0, 255));
				asc = 1'($urandom_range(0, 1));
			end
			add_byte(b, asc, k == n - 1);
		end
	endtask

	initial begin
		int         phase;
		int         left;
		int         len;
		int         cnt;
		logic [7:0] lim;
		logic [7:0] pre;

		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: literals, escapes, space and tab inside and at the end
		add_byte("A", 1'b1, 1'b0);
		add_byte(PRINT_LOW, 1'b1, 1'b0);
		add_byte(PRINT_HIGH, 1'b1, 1'b0);
		add_byte(CHAR_EQUALS, 1'b1, 1'b0);
		add_byte(CHAR_SPACE, 1'b1, 1'b0);
		add_byte(CHAR_TAB, 1'b1, 1'b0);
		add_byte(CHAR_SPACE, 1'b0, 1'b0);
		add_byte(8'h00, 1'b1, 1'b0);
		add_byte(8'hFF, 1'b1, 1'b0);
		add_byte(8'hFF, 1'b0, 1'b0);
		add_byte(8'h7F, 1'b1, 1'b0);
		add_byte("k", 1'b0, 1'b0);
		add_byte(CHAR_SPACE, 1'b1, 1'b1);
		add_byte(CHAR_TAB, 1'b1, 1'b1);
		wait_idle();

		// short limit: a soft break before an escape
		add_write(REG_LINE_LIMIT, 8'd8);
		add_write(REG_PREFIX_LENGTH, 8'd0);
		wait_idle();
		add_byte("a", 1'b1, 1'b0);
		add_byte("b", 1'b1, 1'b0);
		add_byte("c", 1'b1, 1'b0);
		add_byte("d", 1'b1, 1'b0);
		add_byte("e", 1'b1, 1'b0);
		add_byte(8'hC3, 1'b0, 1'b0);
		add_byte(8'hA9, 1'b0, 1'b0);
		add_byte("z", 1'b1, 1'b1);
		wait_idle();

		// prefix past the limit: negative room breaks the first line once it is nonempty
		add_write(REG_LINE_LIMIT, 8'd3);
		add_write(REG_PREFIX_LENGTH, 8'd5);
		wait_idle();
		add_byte("p", 1'b1, 1'b0);
		add_byte("q", 1'b1, 1'b0);
		add_byte("r", 1'b1, 1'b1);
		wait_idle();

		// random texts under a range of settings
		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin lim = 8'd76;  pre = 8'd0;   cnt = 20; end
				1: begin lim = 8'd8;   pre = 8'd0;   cnt = 20; end
				2: begin lim = 8'd255; pre = 8'd255; cnt = 15; end
				3: begin lim = 8'd255; pre = 8'd200; cnt = 20; end
				4: begin lim = 8'd8;   pre = 8'd255; cnt = 15; end
				5: begin lim = 8'd0;   pre = 8'd0;   cnt = 15; end
				6: begin lim = 8'd40;  pre = 8'd30;  cnt = 30; end
				default: begin
					lim = 8'($urandom_range(8, 255));
					pre = 8'($urandom_range(0, 255));
					cnt = 10;
				end
			endcase
			add_write(REG_LINE_LIMIT, lim);
			add_write(REG_PREFIX_LENGTH, pre);
			if (phase == 3) begin
				add_write(REG_SPARE_A, 8'($urandom_range(0, 255)));
				add_write(REG_SPARE_B, 8'($urandom_range(0, 255)));
			end
			wait_idle();
			left = cnt;
			while (left > 0) begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 60)
					: $urandom_range(1, 12);
				if (len > left) len = left;
				add_random_text(len);
				left -= len;
			end
			wait_idle();
		end

		if (fail_count == 0) begin
			$display("tb_quoted_printable_encoder: clean");
		end else begin
			$display("tb_quoted_printable_encoder: errors");
		end
		$finish;
	end

endmodule
